// File: rtl/cbh_pkg.sv
package cbh_pkg;

    localparam int LEVELS      = 16;
    localparam int Q_W         = $clog2(LEVELS);
    localparam int LUMA_BINS   = 16;
    localparam int LUMA_BIN_W  = $clog2(LUMA_BINS);
    localparam int BUCKET_AW   = 12;
    localparam int SUM_W       = 32;
    localparam int COUNT_W     = 24;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam logic [COUNT_W-1:0]   COUNT_MAX      = '1;
    localparam logic [BUCKET_AW-1:0] LAST_BUCKET    = '1;
    localparam logic [12:0]          WIDTH_MAX      = 13'd4096;
    localparam logic [12:0]          WIDTH_RESET    = 13'd640;
    localparam logic [7:0]           STEP_RESET     = 8'd1;

    typedef enum logic [1:0] {
        REQ_PIXEL       = 2'd0,
        REQ_CLEAR       = 2'd1,
        REQ_READ_BUCKET = 2'd2,
        REQ_READ_LUMA   = 2'd3
    } t_req;

    typedef enum logic {
        CFG_FRAME_WIDTH = 1'b0,
        CFG_SAMPLE_STEP = 1'b1
    } t_cfg_index;

    // one accepted beat after position tracking and bucket indexing
    typedef struct packed {
        logic                   valid;
        t_req                   req;
        logic                   keep;
        logic [BUCKET_AW-1:0]   addr;
        logic [7:0]             red;
        logic [7:0]             green;
        logic [7:0]             blue;
        logic [LUMA_BIN_W-1:0]  bin;
    } t_stage;

    typedef struct packed {
        logic [SUM_W-1:0]   red_sum;
        logic [SUM_W-1:0]   green_sum;
        logic [SUM_W-1:0]   blue_sum;
        logic [COUNT_W-1:0] count;
    } t_bucket;

    typedef struct packed {
        logic [SUM_W-1:0]   red_sum;
        logic [SUM_W-1:0]   green_sum;
        logic [SUM_W-1:0]   blue_sum;
        logic [COUNT_W-1:0] bucket_count;
        logic [COUNT_W-1:0] luma_count;
        logic [COUNT_W-1:0] sample_total;
    } t_result;

    // round to LEVELS steps: (c*(LEVELS-1)+127)/255 as a threshold search
    function automatic logic [Q_W-1:0] quantize(input logic [7:0] c);
        logic [11:0]    scaled;
        logic [Q_W-1:0] q;
        scaled = 12'(c) * 12'(LEVELS - 1) + 12'd127;
        q = '0;
        for (int k = 1; k < LEVELS; k++) begin
            if (scaled >= 12'(255 * k)) begin
                q = Q_W'(k);
            end
        end
        return q;
    endfunction

    function automatic logic [BUCKET_AW-1:0] bucket_index(
        input logic [Q_W-1:0] qr,
        input logic [Q_W-1:0] qg,
        input logic [Q_W-1:0] qb
    );
        logic [BUCKET_AW-1:0] idx;
        idx = BUCKET_AW'(qr) * BUCKET_AW'(LEVELS) + BUCKET_AW'(qg);
        idx = idx * BUCKET_AW'(LEVELS) + BUCKET_AW'(qb);
        return idx;
    endfunction

endpackage

// File: rtl/cbh_sampler.sv
module cbh_sampler import cbh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_req        i_req,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [11:0] i_read_index,
    input  logic [12:0] i_frame_width,
    input  logic [7:0]  i_sample_step,
    output t_stage      o_stage
);

    logic [11:0] r_col_pos;
    logic [7:0]  r_col_phase;
    logic [7:0]  r_row_phase;
    t_stage      r_stage;

    logic [7:0]  step_eff;
    logic [12:0] width_eff;
    logic        row_end;
    logic [7:0]  col_phase_inc;
    logic [7:0]  row_phase_inc;
    logic [15:0] luma_sum;
    logic [BUCKET_AW-1:0] pix_index;
    t_stage      n_stage;

    always_comb begin
        step_eff  = (i_sample_step == 8'd0) ? 8'd1 : i_sample_step;
        width_eff = (i_frame_width == 13'd0) ? 13'd1 :
                    ((i_frame_width > WIDTH_MAX) ? WIDTH_MAX : i_frame_width);
        row_end   = ({1'b0, r_col_pos} + 13'd1) >= width_eff;
        // a phase at or past the step wraps on its next advance
        col_phase_inc = (({1'b0, r_col_phase} + 9'd1) >= {1'b0, step_eff}) ?
                        8'd0 : r_col_phase + 8'd1;
        row_phase_inc = (({1'b0, r_row_phase} + 9'd1) >= {1'b0, step_eff}) ?
                        8'd0 : r_row_phase + 8'd1;

        luma_sum  = 16'(i_red) * 16'd54 + 16'(i_green) * 16'd183 + 16'(i_blue) * 16'd19;
        pix_index = bucket_index(quantize(i_red), quantize(i_green), quantize(i_blue));

        n_stage       = '0;
        n_stage.valid = i_accept;
        n_stage.req   = i_req;
        n_stage.keep  = (r_col_phase == 8'd0) && (r_row_phase == 8'd0);
        n_stage.addr  = (i_req == REQ_PIXEL) ? pix_index : i_read_index;
        n_stage.red   = i_red;
        n_stage.green = i_green;
        n_stage.blue  = i_blue;
        n_stage.bin   = luma_sum[15:12];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos     <= '0;
            r_col_phase   <= '0;
            r_row_phase   <= '0;
            r_stage       <= '0;
        end else begin
            r_stage <= n_stage;
            if (i_accept) begin
                if (i_req == REQ_CLEAR) begin
                    r_col_pos   <= '0;
                    r_col_phase <= '0;
                    r_row_phase <= '0;
                end else if (i_req == REQ_PIXEL) begin
                    if (row_end) begin
                        r_col_pos   <= '0;
                        r_col_phase <= '0;
                        r_row_phase <= row_phase_inc;
                    end else begin
                        r_col_pos   <= r_col_pos + 12'd1;
                        r_col_phase <= col_phase_inc;
                    end
                end
            end
        end
    end

    assign o_stage = r_stage;

endmodule

// File: rtl/color_bucket_histogram_core.sv
// Color-bucket and luma histogram of a sampled RGB stream. Pixel beats and read
// beats are taken one per cycle while o_in_stall is low; a read result passes the
// sampler register and the memory-read stage into a four-entry result queue, so
// a stalled output holds back new beats once four results are owed. The bucket
// store is one 4096-entry memory with a registered read, updated read-modify-write
// with forwarding of the last write. After reset and after every clear beat (once
// it reaches the second stage) the block zeroes all 4096 entries, one per cycle,
// and takes no beat until the sweep ends; configuration writes are always taken.
module color_bucket_histogram_core import cbh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [11:0] i_read_index,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_red_sum,
    output logic [31:0] o_green_sum,
    output logic [31:0] o_blue_sum,
    output logic [23:0] o_bucket_count,
    output logic [23:0] o_luma_count,
    output logic [23:0] o_sample_total,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    logic [12:0]           r_frame_width;
    logic [7:0]            r_sample_step;

    t_bucket               r_mem [2**BUCKET_AW];
    t_bucket               r_q;
    t_stage                s1;
    t_stage                r_s2;

    logic                  r_lw_valid;
    logic [BUCKET_AW-1:0]  r_lw_addr;
    t_bucket               r_lw_data;

    logic [COUNT_W-1:0]    r_luma_bins [LUMA_BINS];
    logic [COUNT_W-1:0]    r_kept;

    logic                  r_sweep;
    logic [BUCKET_AW-1:0]  r_sweep_addr;
    logic                  r_clr_wait;

    t_result               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wp;
    logic [FIFO_AW-1:0]    r_rp;
    logic [FIFO_CW-1:0]    r_fcnt;
    logic [FIFO_CW-1:0]    r_pending;

    logic                  in_accept;
    logic                  in_is_read;
    logic                  out_beat;
    t_bucket               old;
    t_bucket               n_bucket;
    logic                  s2_kept_pixel;
    logic                  bucket_wr;
    logic                  s2_read;
    logic                  s2_clear;
    t_result               n_result;
    logic                  mem_we;
    logic [BUCKET_AW-1:0]  mem_waddr;
    t_bucket               mem_wdata;
    t_req                  in_req;

    assign in_req      = t_req'(i_req_type);
    assign o_in_stall  = r_sweep || r_clr_wait || (r_pending == FIFO_CW'(FIFO_DEPTH));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_is_read  = (in_req == REQ_READ_BUCKET) || (in_req == REQ_READ_LUMA);
    assign o_out_valid = (r_fcnt != '0);
    assign out_beat    = o_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    cbh_sampler u_sampler (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_req         (in_req),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_read_index  (i_read_index),
        .i_frame_width (r_frame_width),
        .i_sample_step (r_sample_step),
        .o_stage       (s1)
    );

    always_comb begin
        // the write of the previous cycle is not yet in the read data
        old = (r_lw_valid && (r_lw_addr == r_s2.addr)) ? r_lw_data : r_q;

        n_bucket.red_sum   = old.red_sum + SUM_W'(r_s2.red);
        n_bucket.green_sum = old.green_sum + SUM_W'(r_s2.green);
        n_bucket.blue_sum  = old.blue_sum + SUM_W'(r_s2.blue);
        n_bucket.count     = old.count + COUNT_W'(1);

        s2_kept_pixel = r_s2.valid && (r_s2.req == REQ_PIXEL) && r_s2.keep;
        bucket_wr     = s2_kept_pixel && (old.count != COUNT_MAX);
        s2_read       = r_s2.valid &&
                        ((r_s2.req == REQ_READ_BUCKET) || (r_s2.req == REQ_READ_LUMA));
        s2_clear      = r_s2.valid && (r_s2.req == REQ_CLEAR);

        n_result = '0;
        n_result.sample_total = r_kept;
        if (r_s2.req == REQ_READ_BUCKET) begin
            n_result.red_sum      = old.red_sum;
            n_result.green_sum    = old.green_sum;
            n_result.blue_sum     = old.blue_sum;
            n_result.bucket_count = old.count;
        end else if (r_s2.addr < BUCKET_AW'(LUMA_BINS)) begin
            n_result.luma_count = r_luma_bins[r_s2.addr[LUMA_BIN_W-1:0]];
        end

        mem_we    = r_sweep || bucket_wr;
        mem_waddr = r_sweep ? r_sweep_addr : r_s2.addr;
        mem_wdata = r_sweep ? '0 : n_bucket;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_q <= r_mem[s1.addr];
    end

    always_ff @(posedge i_clk) begin
        r_lw_addr <= r_s2.addr;
        r_lw_data <= n_bucket;
        if (s2_read) begin
            r_fifo[r_wp] <= n_result;
        end
        if (!i_rst_n) begin
            r_frame_width <= WIDTH_RESET;
            r_sample_step <= STEP_RESET;
            r_s2          <= '0;
            r_lw_valid    <= 1'b0;
            r_kept        <= '0;
            for (int i = 0; i < LUMA_BINS; i++) begin
                r_luma_bins[i] <= '0;
            end
            r_sweep       <= 1'b1;
            r_sweep_addr  <= '0;
            r_clr_wait    <= 1'b0;
            r_wp          <= '0;
            r_rp          <= '0;
            r_fcnt        <= '0;
            r_pending     <= '0;
        end else begin
            r_s2 <= s1;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_FRAME_WIDTH: r_frame_width <= i_cfg_data;
                    CFG_SAMPLE_STEP: r_sample_step <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            r_lw_valid <= bucket_wr && !r_sweep;

            if (s2_kept_pixel) begin
                if (r_luma_bins[r_s2.bin] != COUNT_MAX) begin
                    r_luma_bins[r_s2.bin] <= r_luma_bins[r_s2.bin] + COUNT_W'(1);
                end
                if (r_kept != COUNT_MAX) begin
                    r_kept <= r_kept + COUNT_W'(1);
                end
            end

            if (in_accept && (in_req == REQ_CLEAR)) begin
                r_clr_wait <= 1'b1;
            end
            if (s2_clear) begin
                r_clr_wait   <= 1'b0;
                r_sweep      <= 1'b1;
                r_sweep_addr <= '0;
                r_kept       <= '0;
                for (int i = 0; i < LUMA_BINS; i++) begin
                    r_luma_bins[i] <= '0;
                end
            end else if (r_sweep) begin
                r_sweep_addr <= r_sweep_addr + BUCKET_AW'(1);
                if (r_sweep_addr == LAST_BUCKET) begin
                    r_sweep <= 1'b0;
                end
            end

            // a result slot is owed from acceptance until its output beat
            r_pending <= r_pending + FIFO_CW'(in_accept && in_is_read) - FIFO_CW'(out_beat);
            r_fcnt    <= r_fcnt + FIFO_CW'(s2_read) - FIFO_CW'(out_beat);
            if (s2_read) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (out_beat) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
        end
    end

    assign o_red_sum      = r_fifo[r_rp].red_sum;
    assign o_green_sum    = r_fifo[r_rp].green_sum;
    assign o_blue_sum     = r_fifo[r_rp].blue_sum;
    assign o_bucket_count = r_fifo[r_rp].bucket_count;
    assign o_luma_count   = r_fifo[r_rp].luma_count;
    assign o_sample_total = r_fifo[r_rp].sample_total;

`ifndef SYNTHESIS
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_pending)
        else $error("result queue holds more than was reserved");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= FIFO_CW'(FIFO_DEPTH))
        else $error("more results owed than queue entries");

    a_no_pixel_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep |-> !bucket_wr)
        else $error("bucket update during clearing sweep");

    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_clear |=> r_sweep && (r_sweep_addr == '0))
        else $error("clear did not start the sweep");

    a_stall_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (in_req == REQ_CLEAR)) |=> o_in_stall ##1 o_in_stall)
        else $error("beat taken while a clear is in flight");
`endif

endmodule

// File: sim/color_bucket_histogram_checker.sv
`timescale 1ns / 1ps

module color_bucket_histogram_checker import cbh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [11:0] i_read_index,

    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_red_sum,
    input  logic [31:0] i_green_sum,
    input  logic [31:0] i_blue_sum,
    input  logic [23:0] i_bucket_count,
    input  logic [23:0] i_luma_count,
    input  logic [23:0] i_sample_total,

    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,

    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam int LUMA_R_WEIGHT = 54;
    localparam int LUMA_G_WEIGHT = 183;
    localparam int LUMA_B_WEIGHT = 19;
    localparam int BUCKET_DEPTH  = 1 << BUCKET_AW;

    logic [SUM_W-1:0]   red_acc   [BUCKET_DEPTH];
    logic [SUM_W-1:0]   green_acc [BUCKET_DEPTH];
    logic [SUM_W-1:0]   blue_acc  [BUCKET_DEPTH];
    logic [COUNT_W-1:0] hits      [BUCKET_DEPTH];
    logic [COUNT_W-1:0] luma_hist [LUMA_BINS];
    logic [COUNT_W-1:0] kept_total;
    logic [11:0]        col_pos;
    logic [7:0]         col_phase;
    logic [7:0]         row_phase;
    logic [12:0]        width_reg;
    logic [7:0]         step_reg;

    t_result            owed_results [$];
    int                 fail_count;
    int                 checked;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= 25) begin
            $display("%0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
        end
    endtask

    function automatic void empty_stores();
        for (int k = 0; k < BUCKET_DEPTH; k++) begin
            red_acc[k]   = '0;
            green_acc[k] = '0;
            blue_acc[k]  = '0;
            hits[k]      = '0;
        end
        for (int k = 0; k < LUMA_BINS; k++) begin
            luma_hist[k] = '0;
        end
        kept_total = '0;
        col_pos    = '0;
        col_phase  = '0;
        row_phase  = '0;
    endfunction

    function automatic int level_of(input logic [7:0] c);
        return (int'(c) * (LEVELS - 1) + 127) / 255;
    endfunction

    function automatic void tally_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        logic [BUCKET_AW-1:0] slot;
        int                   luma;
        int                   bin;
        slot = BUCKET_AW'((level_of(r) * LEVELS + level_of(g)) * LEVELS + level_of(b));
        luma = (LUMA_R_WEIGHT * int'(r) + LUMA_G_WEIGHT * int'(g)
                + LUMA_B_WEIGHT * int'(b)) >> 8;
        bin = luma >> 4;
        if (bin > LUMA_BINS - 1) begin
            bin = LUMA_BINS - 1;
        end
        // a full bucket freezes so its sums stay in line with its count
        if (hits[slot] != COUNT_MAX) begin
            red_acc[slot]   += SUM_W'(r);
            green_acc[slot] += SUM_W'(g);
            blue_acc[slot]  += SUM_W'(b);
            hits[slot]      += 1'b1;
        end
        if (luma_hist[bin] != COUNT_MAX) begin
            luma_hist[bin] += 1'b1;
        end
        if (kept_total != COUNT_MAX) begin
            kept_total += 1'b1;
        end
    endfunction

    function automatic void advance_raster();
        int stride;
        int span;
        stride = (step_reg == 0) ? 1 : int'(step_reg);
        span = (width_reg == 0) ? 1 : ((width_reg > WIDTH_MAX) ? int'(WIDTH_MAX)
                                                              : int'(width_reg));
        if (int'(col_pos) + 1 >= span) begin
            col_pos   = '0;
            col_phase = '0;
            row_phase = (int'(row_phase) + 1 >= stride) ? 8'd0 : row_phase + 8'd1;
        end else begin
            col_pos   = col_pos + 12'd1;
            col_phase = (int'(col_phase) + 1 >= stride) ? 8'd0 : col_phase + 8'd1;
        end
    endfunction

    function automatic void absorb_beat(input t_req kind, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b,
                                        input logic [11:0] idx);
        t_result res;
        case (kind)
            REQ_PIXEL: begin
                if (col_phase == 0 && row_phase == 0) begin
                    tally_pixel(r, g, b);
                end
                advance_raster();
            end
            REQ_CLEAR: begin
                empty_stores();
            end
            default: begin
                res = '0;
                res.sample_total = kept_total;
                if (kind == REQ_READ_BUCKET) begin
                    res.red_sum      = red_acc[idx];
                    res.green_sum    = green_acc[idx];
                    res.blue_sum     = blue_acc[idx];
                    res.bucket_count = hits[idx];
                end else if (idx < LUMA_BINS) begin
                    res.luma_count = luma_hist[idx[LUMA_BIN_W-1:0]];
                end
                owed_results = {owed_results, res};
            end
        endcase
    endfunction

    task automatic check_result();
        t_result want;
        if (owed_results.size() == 0) begin
            report_mismatch("result beat with nothing owed, red_sum", i_red_sum, '0);
        end else begin
            want = owed_results.pop_front();
            checked++;
            if (i_red_sum !== want.red_sum)
                report_mismatch("red_sum", i_red_sum, want.red_sum);
            if (i_green_sum !== want.green_sum)
                report_mismatch("green_sum", i_green_sum, want.green_sum);
            if (i_blue_sum !== want.blue_sum)
                report_mismatch("blue_sum", i_blue_sum, want.blue_sum);
            if (i_bucket_count !== want.bucket_count)
                report_mismatch("bucket_count", 32'(i_bucket_count), 32'(want.bucket_count));
            if (i_luma_count !== want.luma_count)
                report_mismatch("luma_count", 32'(i_luma_count), 32'(want.luma_count));
            if (i_sample_total !== want.sample_total)
                report_mismatch("sample_total", 32'(i_sample_total), 32'(want.sample_total));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            empty_stores();
            width_reg = WIDTH_RESET;
            step_reg  = STEP_RESET;
            owed_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_FRAME_WIDTH: width_reg = i_cfg_data;
                    CFG_SAMPLE_STEP: step_reg  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_beat(t_req'(i_req_type), i_red, i_green, i_blue, i_read_index);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= owed_results.size();
        o_checked    <= checked;
    end

endmodule

// File: sim/tb_color_bucket_histogram_core.sv
`timescale 1ns / 1ps

module tb_color_bucket_histogram_core;
    import cbh_pkg::*;

    localparam int PHASES     = 11;
    localparam int PHASE_LEN  = 68;
    localparam int HOLD_CYCLES = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type = REQ_PIXEL;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic [11:0] i_read_index = '0;

    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_red_sum;
    logic [31:0] o_green_sum;
    logic [31:0] o_blue_sum;
    logic [23:0] o_bucket_count;
    logic [23:0] o_luma_count;
    logic [23:0] o_sample_total;

    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_FRAME_WIDTH;
    logic [12:0] i_cfg_data = '0;

    int          fail_count;
    int          pending;
    int          checked;

    bit          hold_off_req = 1'b0;
    bit          burst_mode = 1'b0;
    int          pixels_sent;
    int          reads_sent;
    int          clears_sent;
    int          settings_used;
    logic [3:0]  palette [6][3];

    int          frame_widths [PHASES] = '{5, 1, 0, 7, 4096, 8191, 6, 2, 9, 640, 3};
    int          sample_steps [PHASES] = '{2, 1, 3, 0, 255, 1, 3, 1, 4, 7, 255};

    color_bucket_histogram_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red_sum      (o_red_sum),
        .o_green_sum    (o_green_sum),
        .o_blue_sum     (o_blue_sum),
        .o_bucket_count (o_bucket_count),
        .o_luma_count   (o_luma_count),
        .o_sample_total (o_sample_total),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    color_bucket_histogram_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_read_index   (i_read_index),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_red_sum      (o_red_sum),
        .i_green_sum    (o_green_sum),
        .i_blue_sum     (o_blue_sum),
        .i_bucket_count (o_bucket_count),
        .i_luma_count   (o_luma_count),
        .i_sample_total (o_sample_total),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results still owed", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // output side: quiet stretches, short stalls, the odd long one, and a
    // requested hold-off long enough to back the block up
    initial begin
        int   left;
        int   roll;
        logic level;
        left  = 0;
        level = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                level = 1'b1;
                left  = HOLD_CYCLES;
            end else if (left == 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    level = 1'b0;
                    left  = $urandom_range(1, 40);
                end else if (roll < 75) begin
                    level = 1'b0;
                    left  = $urandom_range(1, 3);
                end else if (roll < 95) begin
                    level = 1'b1;
                    left  = $urandom_range(1, 3);
                end else begin
                    level = 1'b1;
                    left  = $urandom_range(8, 30);
                end
            end
            i_out_stall <= level;
            left--;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // a byte that rounds to the given level, jittered inside its window
    function automatic logic [7:0] byte_near(input logic [3:0] lv);
        int v;
        v = (int'(lv) * 255 + 7) / 15 + $urandom_range(0, 8) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    task automatic push_beat(input t_req req, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [11:0] idx);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_red        <= r;
        i_green      <= g;
        i_blue       <= b;
        i_read_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        case (req)
            REQ_PIXEL: pixels_sent++;
            REQ_CLEAR: clears_sent++;
            default:   reads_sent++;
        endcase
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        // pixel beats leave no result, give them time to land
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index which, input logic [12:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic pixel_beat(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        push_beat(REQ_PIXEL, r, g, b, 12'($urandom));
    endtask

    task automatic read_beat(input t_req req, input logic [11:0] idx);
        push_beat(req, 8'($urandom), 8'($urandom), 8'($urandom), idx);
    endtask

    task automatic random_beat();
        int roll;
        int k;
        roll = $urandom_range(0, 99);
        k    = $urandom_range(0, 5);
        if (roll < 55)
            pixel_beat(byte_near(palette[k][0]), byte_near(palette[k][1]),
                       byte_near(palette[k][2]));
        else if (roll < 70)
            pixel_beat(8'($urandom), 8'($urandom), 8'($urandom));
        else if (roll < 82)
            read_beat(REQ_READ_BUCKET, {palette[k][0], palette[k][1], palette[k][2]});
        else if (roll < 88)
            read_beat(REQ_READ_BUCKET, 12'($urandom));
        else if (roll < 95)
            read_beat(REQ_READ_LUMA, 12'($urandom_range(0, LUMA_BINS - 1)));
        else if (roll < 98)
            read_beat(REQ_READ_LUMA, 12'($urandom));
        else
            read_beat(REQ_CLEAR, 12'($urandom));
    endtask

    initial begin
        int spin;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: channel extremes, rounding edges, every request kind
        pixel_beat(8'd0, 8'd0, 8'd0);
        pixel_beat(8'd255, 8'd255, 8'd255);
        pixel_beat(8'd255, 8'd0, 8'd0);
        pixel_beat(8'd0, 8'd255, 8'd0);
        pixel_beat(8'd0, 8'd0, 8'd255);
        pixel_beat(8'd8, 8'd9, 8'd8);
        pixel_beat(8'd127, 8'd128, 8'd247);
        pixel_beat(8'd255, 8'd255, 8'd255);
        read_beat(REQ_READ_BUCKET, 12'h000);
        read_beat(REQ_READ_BUCKET, 12'hfff);
        read_beat(REQ_READ_BUCKET, 12'hf00);
        read_beat(REQ_READ_BUCKET, 12'h0f0);
        read_beat(REQ_READ_BUCKET, 12'h00f);
        read_beat(REQ_READ_BUCKET, 12'h010);
        read_beat(REQ_READ_LUMA, 12'd0);
        read_beat(REQ_READ_LUMA, 12'd8);
        read_beat(REQ_READ_LUMA, 12'd15);
        // luma bin past the last one reads as zero
        read_beat(REQ_READ_LUMA, 12'd16);
        read_beat(REQ_READ_LUMA, 12'hfff);
        read_beat(REQ_CLEAR, 12'd0);
        read_beat(REQ_READ_BUCKET, 12'hfff);
        read_beat(REQ_READ_LUMA, 12'd15);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_reg(CFG_FRAME_WIDTH, 13'(frame_widths[ph]));
            write_reg(CFG_SAMPLE_STEP, 13'(sample_steps[ph]));
            settings_used++;
            for (int k = 0; k < 6; k++) begin
                for (int c = 0; c < 3; c++) palette[k][c] = 4'($urandom);
            end
            burst_mode = ($urandom_range(0, 3) == 0);
            // other phases keep the raster position so the step changes mid-frame
            if (ph % 3 == 0) read_beat(REQ_CLEAR, 12'($urandom));
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (ph == 4 && n == 20) begin
                    hold_off_req = 1'b1;
                    burst_mode   = 1'b1;
                    for (int k = 0; k < 16; k++) begin
                        read_beat(REQ_READ_BUCKET,
                                  {palette[k % 6][0], palette[k % 6][1], palette[k % 6][2]});
                    end
                    burst_mode = 1'b0;
                end
                if (ph == 6 && n == 30) wait_drained();
                random_beat();
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        for (spin = 0; spin < 20000 && pending != 0; spin++) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("beats sent: %0d pixels, %0d reads, %0d clears; %0d results compared",
                 pixels_sent, reads_sent, clears_sent, checked);
        $display("register settings exercised after the defaults: %0d", settings_used);
        if (pending != 0) $display("results still owed at the end: %0d", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/cbh_pkg.sv
rtl/cbh_sampler.sv
rtl/color_bucket_histogram_core.sv
sim/color_bucket_histogram_checker.sv
sim/tb_color_bucket_histogram_core.sv
